@@ hw/rtl/hss_pkg.sv @@
// Shared types, register indexes, codes and constants of the heater source selector.
package hss_pkg;

    localparam int NUM_WINDOWS = 4;
    localparam int TEMP_W      = 12;
    localparam int VOLTS_W     = 10;
    localparam int MINUTE_W    = 11;
    localparam int WINDOW_W    = 30;
    localparam int CFG_DATA_W  = 30;
    localparam int CFG_IDX_W   = 3;
    localparam int DUTY_W      = 8;

    localparam logic [VOLTS_W-1:0] MIN_PANEL_VOLTS = 10'd100;
    localparam logic [DUTY_W-1:0]  PWM_FULL_LEVEL  = 8'd255;
    localparam logic [DUTY_W-1:0]  HALF_DUTY       = 8'd128;
    localparam logic [DUTY_W-1:0]  DUTY_OFF        = 8'd0;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOLAR_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AC_THRESHOLD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OVERTEMP_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_A        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_B        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_C        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_D        = 3'd7;

    // Heating modes
    localparam logic [1:0] MODE_OFF       = 2'd0;
    localparam logic [1:0] MODE_SOLAR     = 2'd1;
    localparam logic [1:0] MODE_AC        = 2'd2;
    localparam logic [1:0] MODE_SOLAR_AC  = 2'd3;

    // Reported states
    localparam logic [1:0] ST_OFF         = 2'd0;
    localparam logic [1:0] ST_SOLAR_ON    = 2'd1;
    localparam logic [1:0] ST_AC_ON       = 2'd2;
    localparam logic [1:0] ST_TEMP_REACHED = 2'd3;

    localparam logic signed [TEMP_W-1:0] SOLAR_THRESHOLD_RST = 12'sd600;
    localparam logic signed [TEMP_W-1:0] AC_THRESHOLD_RST    = 12'sd550;
    localparam logic signed [TEMP_W-1:0] OVERTEMP_LIMIT_RST  = 12'sd800;

    typedef struct packed {
        logic [1:0]                             heat_mode;
        logic signed [TEMP_W-1:0]               solar_threshold;
        logic signed [TEMP_W-1:0]               ac_threshold;
        logic signed [TEMP_W-1:0]               overtemp_limit;
        logic [NUM_WINDOWS-1:0][WINDOW_W-1:0]   windows;
    } cfg_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] water_temp;
        logic                     temp_ok;
        logic [VOLTS_W-1:0]       panel_volts;
        logic                     clock_synced;
        logic [2:0]               week_day;
        logic [MINUTE_W-1:0]      day_minute;
    } sample_t;

    typedef struct packed {
        logic              relay_drive;
        logic [DUTY_W-1:0] ssr_duty;
        logic [1:0]        heat_state;
    } result_t;

endpackage

@@ hw/rtl/heater_source_selector.sv @@
// Heater source selector: a registered request, the decision logic and a registered result.
// An accepted request is registered in the input stage, then its result on the m_ side.
// One request per cycle while m_ready holds; the decision is one pass through compare logic.
// A request is taken while a result waits, as long as the input stage can move on.
// Synchronous active-low reset empties both stages and loads the register reset values.
module heater_source_selector (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [hss_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [hss_pkg::TEMP_W-1:0]    s_water_temp,
    input  logic                                 s_temp_ok,
    input  logic [hss_pkg::VOLTS_W-1:0]          s_panel_volts,
    input  logic                                 s_clock_synced,
    input  logic [2:0]                           s_week_day,
    input  logic [hss_pkg::MINUTE_W-1:0]         s_day_minute,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_relay_drive,
    output logic [hss_pkg::DUTY_W-1:0]           m_ssr_duty,
    output logic [1:0]                           m_heat_state
);
    import hss_pkg::*;

    cfg_t    cfg;
    sample_t sample_reg;
    logic    in_valid_reg;
    result_t res_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    out_load;
    logic    in_load;

    hss_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hss_decide u_decide (
        .cfg    (cfg),
        .sample (sample_reg),
        .result (res_next)
    );

    // The result register frees up when it is empty or its result is being taken.
    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            sample_reg.water_temp   <= s_water_temp;
            sample_reg.temp_ok      <= s_temp_ok;
            sample_reg.panel_volts  <= s_panel_volts;
            sample_reg.clock_synced <= s_clock_synced;
            sample_reg.week_day     <= s_week_day;
            sample_reg.day_minute   <= s_day_minute;
        end
        if (out_load) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_relay_drive = res_reg.relay_drive;
    assign m_ssr_duty    = res_reg.ssr_duty;
    assign m_heat_state  = res_reg.heat_state;

endmodule

@@ hw/rtl/hss_cfg_regs.sv @@
// Configuration register file of the heater source selector.
module hss_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [hss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output hss_pkg::cfg_t                    cfg
);
    import hss_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_HEAT_MODE:       cfg_next.heat_mode       = cfg_wdata[1:0];
                REG_SOLAR_THRESHOLD: cfg_next.solar_threshold = cfg_wdata[TEMP_W-1:0];
                REG_AC_THRESHOLD:    cfg_next.ac_threshold    = cfg_wdata[TEMP_W-1:0];
                REG_OVERTEMP_LIMIT:  cfg_next.overtemp_limit  = cfg_wdata[TEMP_W-1:0];
                REG_WINDOW_A:        cfg_next.windows[0]      = cfg_wdata[WINDOW_W-1:0];
                REG_WINDOW_B:        cfg_next.windows[1]      = cfg_wdata[WINDOW_W-1:0];
                REG_WINDOW_C:        cfg_next.windows[2]      = cfg_wdata[WINDOW_W-1:0];
                REG_WINDOW_D:        cfg_next.windows[3]      = cfg_wdata[WINDOW_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.heat_mode       <= MODE_OFF;
            cfg_reg.solar_threshold <= SOLAR_THRESHOLD_RST;
            cfg_reg.ac_threshold    <= AC_THRESHOLD_RST;
            cfg_reg.overtemp_limit  <= OVERTEMP_LIMIT_RST;
            cfg_reg.windows         <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/hss_window_match.sv @@
// Checks one day-masked minute window against the current day and minute.
module hss_window_match (
    input  logic [hss_pkg::WINDOW_W-1:0]  window,
    input  logic                          clock_synced,
    input  logic [2:0]                    week_day,
    input  logic [hss_pkg::MINUTE_W-1:0]  day_minute,
    output logic                          enabled,
    output logic                          active
);
    import hss_pkg::*;

    logic [6:0]          day_mask;
    logic [2:0]          day_bit;
    logic [MINUTE_W-1:0] start_min;
    logic [MINUTE_W-1:0] end_min;
    logic                in_range;

    assign enabled   = window[0];
    assign day_mask  = window[7:1];
    assign start_min = window[18:8];
    assign end_min   = window[29:19];

    // Sunday is day zero but sits in the top bit of the mask.
    assign day_bit = (week_day == 3'd0) ? 3'd6 : week_day - 3'd1;

    // A window whose start lies after its end wraps over midnight.
    always_comb begin
        if (start_min <= end_min) begin
            in_range = (day_minute >= start_min) && (day_minute < end_min);
        end else begin
            in_range = (day_minute >= start_min) || (day_minute < end_min);
        end
    end

    assign active = enabled && clock_synced && (week_day != 3'd7)
                    && day_mask[day_bit] && in_range;

endmodule

@@ hw/rtl/hss_decide.sv @@
// Heating decision: over-temperature cutoff, then the choice by heating mode.
module hss_decide (
    input  hss_pkg::cfg_t     cfg,
    input  hss_pkg::sample_t  sample,
    output hss_pkg::result_t  result
);
    import hss_pkg::*;

    logic [NUM_WINDOWS-1:0] win_enabled;
    logic [NUM_WINDOWS-1:0] win_active;
    logic                   in_window;
    logic                   pv;
    logic                   need_pv;
    logic                   need_ac;
    logic                   overtemp;

    for (genvar i = 0; i < NUM_WINDOWS; i++) begin : g_win
        hss_window_match u_win (
            .window       (cfg.windows[i]),
            .clock_synced (sample.clock_synced),
            .week_day     (sample.week_day),
            .day_minute   (sample.day_minute),
            .enabled      (win_enabled[i]),
            .active       (win_active[i])
        );
    end

    // With no window enabled, mains heating is allowed at any time.
    assign in_window = ~(|win_enabled) || (|win_active);
    assign pv        = sample.panel_volts >= MIN_PANEL_VOLTS;
    assign need_pv   = !sample.temp_ok || (sample.water_temp < cfg.solar_threshold);
    assign need_ac   = !sample.temp_ok || (sample.water_temp < cfg.ac_threshold);
    assign overtemp  = sample.temp_ok && (sample.water_temp >= cfg.overtemp_limit);

    always_comb begin
        result.relay_drive = 1'b0;
        result.ssr_duty    = DUTY_OFF;
        result.heat_state  = ST_OFF;
        if (overtemp) begin
            result.heat_state = ST_TEMP_REACHED;
        end else begin
            case (cfg.heat_mode)
                MODE_SOLAR: begin
                    if (pv && need_pv) begin
                        result.ssr_duty   = HALF_DUTY;
                        result.heat_state = ST_SOLAR_ON;
                    end else begin
                        result.heat_state = need_pv ? ST_OFF : ST_TEMP_REACHED;
                    end
                end
                MODE_AC: begin
                    if (in_window && need_ac) begin
                        result.relay_drive = 1'b1;
                        result.heat_state  = ST_AC_ON;
                    end else begin
                        result.heat_state = need_ac ? ST_OFF : ST_TEMP_REACHED;
                    end
                end
                MODE_SOLAR_AC: begin
                    if (pv && need_pv) begin
                        result.ssr_duty   = PWM_FULL_LEVEL;
                        result.heat_state = ST_SOLAR_ON;
                    end else if (!pv && in_window && need_ac) begin
                        result.relay_drive = 1'b1;
                        result.heat_state  = ST_AC_ON;
                    end else begin
                        result.heat_state = need_ac ? ST_OFF : ST_TEMP_REACHED;
                    end
                end
                default: begin
                    result.heat_state = ST_OFF;
                end
            endcase
        end
    end

endmodule
